### design/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	// queue geometry
	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// priorities: low is service, mid is medicine, high is fall
	localparam logic [1:0] PRIO_LOW  = 2'd1;
	localparam logic [1:0] PRIO_MID  = 2'd2;
	localparam logic [1:0] PRIO_HIGH = 2'd3;

	// commands
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	// one queue slot
	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [1:0]          prio;
	} slot_t;

	// running winner handed down the chain during a pop scan
	typedef struct packed {
		logic [1:0]          prio;
		logic [TAG_BITS-1:0] tag;
		logic [IDX_W-1:0]    idx;
	} best_t;

	// per-cell controls from the sequencer
	typedef struct packed {
		logic wr;    // take the pushed word
		logic sh;    // take the neighbour's slot (close the gap)
		logic live;  // slot lies below the fill count
	} cell_ctl_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire logic                         clk,
	input  wire logic [spq_pkg::IDX_W-1:0]    index,
	input  wire spq_pkg::cell_ctl_t           ctl,
	input  wire logic [spq_pkg::TAG_BITS-1:0] push_tag,
	input  wire logic [1:0]                   push_prio,
	input  wire spq_pkg::slot_t               nxt,
	output spq_pkg::slot_t                    own,
	input  wire spq_pkg::best_t               best_in,
	output spq_pkg::best_t                    best_out
);

	spq_pkg::slot_t slot_q;
	spq_pkg::best_t best_q;

	// slot storage: written on push, refilled from the next cell on a pop
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			slot_q.tag  <= push_tag;
			slot_q.prio <= push_prio;
		end else if (ctl.sh) begin
			slot_q <= nxt;
		end
	end

	// scan stage: strictly greater wins, so the older entry keeps a tie
	always_ff @(posedge clk) begin
		if (ctl.live && (slot_q.prio > best_in.prio)) begin
			best_q.prio <= slot_q.prio;
			best_q.tag  <= slot_q.tag;
			best_q.idx  <= index;
		end else begin
			best_q <= best_in;
		end
	end

	assign own      = slot_q;
	assign best_out = best_q;

endmodule

`default_nettype wire

### design/stable_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stable priority queue, DEPTH slots of tag and priority (1 service .. 3 fall).
// Request channel: command, priority_req and entry_tag are taken at a rising
// edge with start high and busy low. Command push appends at the tail; pop
// removes the highest priority entry, the oldest one on a tie.
// Result channel: done is high for one cycle with status, popped_tag,
// popped_priority and occupancy; the receiver cannot stall it, so each word
// must be taken in that cycle. Every request gives exactly one result word.
// A push, a refused push (full) and a refused pop (empty) give their result
// in the cycle after acceptance, and busy stays low, so one such request per
// cycle is possible. A successful pop gives its result once the sequencer
// has passed through S_SCAN and S_SHIFT: the winner ripples down the row of
// cells one cell per cycle, then S_SHIFT shifts the later entries up.
// busy is high during that time.
// Reset clears the fill count and the sequencer; slot contents are not
// cleared, slots at or above the fill count are never read.
module stable_priority_queue_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         command,
	input  wire logic [1:0]                   priority_req,
	input  wire logic [spq_pkg::TAG_BITS-1:0] entry_tag,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [spq_pkg::TAG_BITS-1:0]      popped_tag,
	output logic [1:0]                        popped_priority,
	output logic [spq_pkg::CNT_W-1:0]         occupancy
);

	localparam int D = spq_pkg::DEPTH;

	spq_pkg::state_t                state_q, state_d;
	logic [spq_pkg::CNT_W-1:0]      fill_q;
	logic [spq_pkg::IDX_W-1:0]      cnt_q;
	logic                           done_q;
	spq_pkg::status_t               status_q;
	logic [spq_pkg::TAG_BITS-1:0]   ptag_q;
	logic [1:0]                     pprio_q;

	logic                           accept;
	logic                           push_ok;
	logic                           is_full;
	logic                           is_empty;
	logic [1:0]                     push_prio;

	spq_pkg::slot_t                 slots [D];
	spq_pkg::best_t                 chain [D+1];
	spq_pkg::cell_ctl_t             ctl   [D];
	spq_pkg::best_t                 winner;

	assign accept   = start && !busy;
	assign is_full  = (fill_q == spq_pkg::CNT_W'(D));
	assign is_empty = (fill_q == '0);
	assign push_ok  = accept && (command == spq_pkg::CMD_PUSH) && !is_full;
	assign winner   = chain[D];

	// unknown kind is stored as service
	assign push_prio = (priority_req == 2'd0) ? spq_pkg::PRIO_LOW : priority_req;

	assign chain[0] = '0;

	// row of cells
	for (genvar i = 0; i < D; i++) begin : g_cell
		spq_pkg::slot_t nxt_slot;

		if (i < D - 1) begin : g_nb
			assign nxt_slot = slots[i+1];
		end else begin : g_end
			assign nxt_slot = '0;
		end

		assign ctl[i].wr   = push_ok && (fill_q == spq_pkg::CNT_W'(i));
		assign ctl[i].sh   = (state_q == spq_pkg::S_SHIFT)
			&& (spq_pkg::IDX_W'(i) >= winner.idx)
			&& (spq_pkg::CNT_W'(i + 1) < fill_q);
		assign ctl[i].live = (spq_pkg::CNT_W'(i) < fill_q);

		spq_cell u_cell (
			.clk       (clk),
			.index     (spq_pkg::IDX_W'(i)),
			.ctl       (ctl[i]),
			.push_tag  (entry_tag),
			.push_prio (push_prio),
			.nxt       (nxt_slot),
			.own       (slots[i]),
			.best_in   (chain[i]),
			.best_out  (chain[i+1])
		);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			spq_pkg::S_IDLE: begin
				busy = 1'b0;
				if (accept && (command == spq_pkg::CMD_POP) && !is_empty) begin
					state_d = spq_pkg::S_SCAN;
				end
			end
			spq_pkg::S_SCAN: begin
				if (cnt_q == spq_pkg::IDX_W'(D - 1)) begin
					state_d = spq_pkg::S_SHIFT;
				end
			end
			spq_pkg::S_SHIFT: begin
				state_d = spq_pkg::S_IDLE;
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	// scan length counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == spq_pkg::S_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push_ok) begin
			fill_q <= fill_q + 1'b1;
		end else if (state_q == spq_pkg::S_SHIFT) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (command == spq_pkg::CMD_PUSH))
				|| (accept && (command == spq_pkg::CMD_POP) && is_empty)
				|| (state_q == spq_pkg::S_SHIFT);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == spq_pkg::S_SHIFT) begin
			status_q <= spq_pkg::ST_OK;
			ptag_q   <= winner.tag;
			pprio_q  <= winner.prio;
		end else if (accept) begin
			ptag_q  <= '0;
			pprio_q <= 2'd0;
			if (command == spq_pkg::CMD_PUSH) begin
				status_q <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end else begin
				status_q <= spq_pkg::ST_EMPTY;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign popped_tag      = ptag_q;
	assign popped_priority = pprio_q;
	assign occupancy       = fill_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= spq_pkg::CNT_W'(D))
		else $error("fill count beyond depth");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != spq_pkg::ST_OK) |-> (popped_tag == '0) && (popped_priority == 2'd0))
		else $error("refused request carries popped data");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == spq_pkg::ST_EMPTY) |-> (occupancy == '0))
		else $error("empty refusal with entries held");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_SHIFT) |=> done && (status == spq_pkg::ST_OK)
			&& (popped_priority != 2'd0))
		else $error("pop finished without a valid word");

endmodule

`default_nettype wire
